>>> src/spq_pkg.sv
package spq_pkg;

	localparam int KEY_BITS  = 16;
	localparam int ID_BITS   = 16;
	localparam int FILL_BITS = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                 kind;
		logic [KEY_BITS-1:0] entry_key;
		logic [ID_BITS-1:0]  entry_id;
	} req_item_t;

	typedef struct packed {
		status_t              status;
		logic [KEY_BITS-1:0]  out_key;
		logic [ID_BITS-1:0]   out_id;
		logic [FILL_BITS-1:0] fill_count;
	} rsp_item_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [ID_BITS-1:0]  id;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                cmp_en;
		logic                pop;
		logic                ins_en;
		logic                rem_en;
		logic [KEY_BITS-1:0] key;
		logic [ID_BITS-1:0]  id;
	} cell_cmd_t;

endpackage

>>> src/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of DEPTH entry cells.
// Result registered at commit: the item is accepted, all cells compare in parallel in
//   S_CMP, then shift and commit in S_COMMIT once the output register is free.
// A new item is taken only while idle or as the item before it commits, so items never overlap.
// Reset (arst_n low, asynchronous): queue empties, no result pending; cell
//   contents are not cleared and are never read until written.
module sorted_priority_queue_unit #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  spq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output spq_pkg::rsp_item_t rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_CMP    = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t          st_q;
	req_item_t       req_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_next;
	rsp_item_t       rsp_q;
	logic            rsp_valid_q;

	logic            accept;
	logic            out_free;
	logic            commit;
	logic            ins_go;
	logic            rem_go;
	logic            found;
	status_t         status;
	entry_t          taken;
	cell_cmd_t       cmd;

	entry_t          data_w   [DEPTH];
	logic            gt_w     [DEPTH];
	logic            prefix_w [DEPTH];
	logic [DEPTH-1:0] first_w;

	// the output register parts the two sides: a new item can be taken while a
	// result still waits, and commit holds off until that result has left
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign commit    = (st_q == S_COMMIT) && out_free;
	assign req_stall = !((st_q == S_IDLE) || commit);
	assign accept    = req_valid && !req_stall;
	assign found     = prefix_w[DEPTH-1];

	// request decode, evaluated against the flags the cells latched in the compare state
	always_comb begin
		status     = ST_DONE;
		ins_go     = 1'b0;
		rem_go     = 1'b0;
		count_next = count_q;
		unique case (req_q.kind)
			OP_INSERT: begin
				if (count_q == FULL_CNT) begin
					status = ST_FULL;
				end else begin
					ins_go     = 1'b1;
					count_next = count_q + CW'(1);
				end
			end
			OP_POP, OP_REMOVE: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOT_FOUND;
				end else begin
					rem_go     = 1'b1;
					count_next = count_q - CW'(1);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	// removed entry: exactly one cell flags itself as the first match
	always_comb begin
		taken = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_w[i]) begin
				taken = taken | data_w[i];
			end
		end
	end

	always_comb begin
		cmd.cmp_en = (st_q == S_CMP);
		cmd.pop    = (req_q.kind == OP_POP);
		cmd.ins_en = commit && ins_go;
		cmd.rem_en = commit && rem_go;
		cmd.key    = req_q.entry_key;
		cmd.id     = req_q.entry_id;
	end

	// cell row: inserts shift toward the tail, removals pull from the tail side
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left       ((i == 0) ? data_w[i] : data_w[(i == 0) ? 0 : i-1]),
			.gt_left    ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i-1]),
			.right      ((i == DEPTH-1) ? data_w[i] : data_w[(i == DEPTH-1) ? i : i+1]),
			.prefix_in  ((i == 0) ? 1'b0 : prefix_w[(i == 0) ? 0 : i-1]),
			.data       (data_w[i]),
			.gt         (gt_w[i]),
			.prefix_out (prefix_w[i]),
			.first      (first_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					st_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						st_q <= accept ? S_CMP : S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (commit) begin
			rsp_q.status     <= status;
			rsp_q.out_key    <= rem_go ? taken.key : '0;
			rsp_q.out_id     <= rem_go ? taken.id : '0;
			rsp_q.fill_count <= FILL_BITS'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count beyond depth");

	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.fill_count == FILL_BITS'(count_q)))
		else $error("reported fill count differs from held count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the queue");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ST_FULL) |-> (count_q == FULL_CNT))
		else $error("full reported on a queue with room");

	a_single_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem_en |-> $onehot(first_w))
		else $error("removal without exactly one selected cell");

endmodule

>>> src/spq_cell.sv
module spq_cell #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                            clk,
	input  spq_pkg::cell_cmd_t              cmd,
	input  logic [$clog2(DEPTH+1)-1:0]      count,
	input  spq_pkg::entry_t                 left,
	input  logic                            gt_left,
	input  spq_pkg::entry_t                 right,
	input  logic                            prefix_in,
	output spq_pkg::entry_t                 data,
	output logic                            gt,
	output logic                            prefix_out,
	output logic                            first
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] MY_POS = CW'(IDX);

	entry_t data_q;
	logic   gt_q;
	logic   match_q;
	logic   occ;
	logic   at_end;
	logic   take_new;
	logic   hit;

	assign occ      = MY_POS < count;
	assign at_end   = MY_POS == count;
	// new entry lands at the first cell holding a larger key, or just past the tail
	assign take_new = !gt_left && (gt_q || at_end);
	assign hit      = prefix_in | match_q;

	assign data       = data_q;
	assign gt         = gt_q;
	assign prefix_out = hit;
	assign first      = match_q & !prefix_in;

	always_ff @(posedge clk) begin
		if (cmd.cmp_en) begin
			gt_q    <= occ && (data_q.key > cmd.key);
			match_q <= cmd.pop ? (occ && (IDX == 0)) : (occ && (data_q.id == cmd.id));
		end
		if (cmd.ins_en) begin
			if (gt_left) begin
				data_q <= left;
			end else if (take_new) begin
				data_q <= '{key: cmd.key, id: cmd.id};
			end
		end else if (cmd.rem_en && hit) begin
			data_q <= right;
		end
	end

endmodule

>>> tb/sorted_priority_queue_unit_test.sv
`timescale 1ns / 100ps

module sorted_priority_queue_unit_test;

	import spq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 450;   // real requests in the random part
	localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
	localparam int IDLE_LIMIT   = 1000;  // cycles with no handshake before giving up
	localparam int MAX_PRINTS   = 40;

	// random traffic mixes
	localparam int FILL_UP    = 0;
	localparam int DRAIN_DOWN = 1;
	localparam int MIXED      = 2;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	sorted_priority_queue_unit #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Queue predictor: sorted array, head (smallest key) at index 0.
	// Only entries below held_count are ever looked at.
	// ------------------------------------------------------------------
	logic [KEY_BITS-1:0] held_key [DEPTH];
	logic [ID_BITS-1:0]  held_id  [DEPTH];
	int                  held_count;

	// pull out one entry and close the gap behind it
	function automatic void take_entry(input int pos, inout rsp_item_t o);
		int j;
		o.out_key = held_key[pos];
		o.out_id  = held_id[pos];
		for (j = pos; j + 1 < held_count; j++) begin
			held_key[j] = held_key[j + 1];
			held_id[j]  = held_id[j + 1];
		end
		held_count--;
	endfunction

	function automatic rsp_item_t sorted_queue_step(input req_item_t r);
		rsp_item_t o;
		int        pos;
		int        j;
		o = '0;
		o.status = ST_DONE;
		case (r.kind)
			OP_INSERT: begin
				if (held_count >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					// land behind every key that is equal or smaller
					pos = 0;
					while (pos < held_count && held_key[pos] <= r.entry_key)
						pos++;
					for (j = held_count; j > pos; j--) begin
						held_key[j] = held_key[j - 1];
						held_id[j]  = held_id[j - 1];
					end
					held_key[pos] = r.entry_key;
					held_id[pos]  = r.entry_id;
					held_count++;
				end
			end
			OP_POP: begin
				if (held_count == 0)
					o.status = ST_EMPTY;
				else
					take_entry(0, o);
			end
			OP_REMOVE: begin
				if (held_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					// first match from the head wins on duplicate ids
					pos = 0;
					while (pos < held_count && held_id[pos] != r.entry_id)
						pos++;
					if (pos >= held_count)
						o.status = ST_NOT_FOUND;
					else
						take_entry(pos, o);
				end
			end
			default: begin
				// unused kind: no change, plain done
			end
		endcase
		o.fill_count = FILL_BITS'(held_count);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	rsp_item_t rsp_due [$];      // results still owed by the block, oldest first
	bit        typed_fixed;      // current item carries a hand-written result
	rsp_item_t typed_want;
	int        burst_left;
	bit        squeeze;          // asks the receiver for one long hold-off
	int        idle_cycles;
	int        mismatches;
	int        results_seen;
	int        n_insert, n_pop, n_remove, n_none;
	int        n_full, n_empty, n_missing, deepest;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t: result %0d, %s: got 0x%0h, want 0x%0h",
				$time, results_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Monitor: everything is sampled on the rising edge. The result side is
	// handled first; a result is registered only after the compare state, so an item
	// can never be answered on the edge that accepts it anyway.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_side
		rsp_item_t want;
		rsp_item_t got;
		if (arst_n) begin
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles = 0;
			else
				idle_cycles++;

			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					report_mismatch("result with nothing owed", 32'(rsp), 0);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.out_key !== want.out_key)
						report_mismatch("out_key", 32'(rsp.out_key), 32'(want.out_key));
					if (rsp.out_id !== want.out_id)
						report_mismatch("out_id", 32'(rsp.out_id), 32'(want.out_id));
					if (rsp.fill_count !== want.fill_count)
						report_mismatch("fill_count", 32'(rsp.fill_count),
							32'(want.fill_count));
				end
				results_seen++;
			end

			if (req_valid && !req_stall) begin
				// the predictor always advances; typed rows replace its answer
				got = sorted_queue_step(req);
				if (typed_fixed)
					got = typed_want;
				rsp_due.push_back(got);
				case (req.kind)
					OP_INSERT: n_insert++;
					OP_POP:    n_pop++;
					OP_REMOVE: n_remove++;
					default:   n_none++;
				endcase
				case (got.status)
					ST_FULL:      n_full++;
					ST_EMPTY:     n_empty++;
					ST_NOT_FOUND: n_missing++;
					default: ;
				endcase
				if (held_count > deepest)
					deepest = held_count;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender: one item per call, entered and left on a falling edge.
	// Works in bursts; between bursts valid drops for a random gap.
	// ------------------------------------------------------------------
	task automatic offer_item(input req_item_t it, input bit fixed, input rsp_item_t want);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		req_valid   <= 1'b1;
		req         <= it;
		typed_fixed <= fixed;
		typed_want  <= want;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// hold the sender until the block has answered everything
	task automatic drain_all();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	typedef struct {
		req_item_t item;
		bit        fixed;
		rsp_item_t want;
	} stim_row_t;

	stim_row_t stim_rows [$];

	task automatic add_row(input op_t k, input logic [KEY_BITS-1:0] key,
			input logic [ID_BITS-1:0] id, input bit fixed, input rsp_item_t want);
		stim_row_t row;
		row.item.kind      = k;
		row.item.entry_key = key;
		row.item.entry_id  = id;
		row.fixed          = fixed;
		row.want           = want;
		stim_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Receiver: changes its stall pattern every so often, and honors one
	// long hold-off each time the sender raises squeeze.
	// ------------------------------------------------------------------
	initial begin : rsp_side
		int mode;
		int span;
		int hold_left;
		int tick;
		bit stall_next;
		rsp_stall = 1'b0;
		mode      = 0;
		span      = 0;
		hold_left = 0;
		tick      = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (squeeze) begin
				squeeze   = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 120);
			end
			span--;
			if (hold_left > 0) begin
				stall_next = 1'b1;
				hold_left--;
			end else begin
				case (mode)
					0: stall_next = 1'b0;                          // free flow
					1: stall_next = ($urandom_range(0, 2) == 0);   // light
					2: stall_next = ($urandom_range(0, 3) != 0);   // heavy
					default: stall_next = (tick % 3 == 0);         // fixed beat
				endcase
			end
			rsp_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: nothing moving for too long means a hang.
	// ------------------------------------------------------------------
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("no handshake for %0d cycles, %0d results still owed",
			IDLE_LIMIT, rsp_due.size());
		$display("sorted_priority_queue_unit_test: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		req_item_t it;
		rsp_item_t blank;
		int        i;
		int        k;
		int        n_real;
		int        mix;
		int        mix_left;
		int        insert_share;

		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		typed_fixed = 1'b0;
		typed_want  = '0;
		burst_left  = 0;
		squeeze     = 1'b0;
		idle_cycles = 0;
		mismatches  = 0;
		held_count  = 0;
		blank       = '0;

		// empty queue, unused kind
		add_row(OP_POP,    '0, '0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0});
		add_row(OP_REMOVE, '0, '1, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0});
		add_row(OP_NONE,   '1, '1, 1'b1, '{ST_DONE,  16'h0, 16'h0, 5'd0});
		// key extremes, equal keys with a repeated id
		add_row(OP_INSERT, '1, '1, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd1});
		add_row(OP_INSERT, '0, '0, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd2});
		add_row(OP_INSERT, 16'h8000, 16'h1234, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd3});
		add_row(OP_INSERT, 16'h8000, 16'h1234, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd4});
		add_row(OP_INSERT, 16'h8000, 16'hABCD, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd5});
		// id not held, then duplicate id: nearest the head goes
		add_row(OP_REMOVE, '0, 16'h5555, 1'b1, '{ST_NOT_FOUND, 16'h0, 16'h0, 5'd5});
		add_row(OP_REMOVE, '0, 16'h1234, 1'b1, '{ST_DONE, 16'h8000, 16'h1234, 5'd4});
		add_row(OP_POP,    '1, '1, 1'b1, '{ST_DONE, 16'h0, 16'h0, 5'd3});
		// fill to the top, each new key going in ahead of the rest
		for (i = 0; i < 13; i++)
			add_row(OP_INSERT, KEY_BITS'(28672 - i * 256), ID_BITS'(256 + i), 1'b0, blank);
		add_row(OP_INSERT, 16'h0001, 16'h0002, 1'b1, '{ST_FULL, 16'h0, 16'h0, 5'd16});
		// largest key sits at the tail
		add_row(OP_REMOVE, '0, '1, 1'b1, '{ST_DONE, 16'hFFFF, 16'hFFFF, 5'd15});

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			offer_item(stim_rows[i].item, stim_rows[i].fixed, stim_rows[i].want);

		// Random part: phases that lean toward filling, draining or neither,
		// so the queue spends time both near empty and near full.
		n_real   = 0;
		k        = 0;
		mix      = MIXED;
		mix_left = 0;
		while (n_real < RANDOM_ITEMS) begin
			if (mix_left == 0) begin
				mix      = $urandom_range(FILL_UP, MIXED);
				mix_left = $urandom_range(15, 60);
			end
			mix_left--;

			// long receiver hold-off while items keep coming back to back
			if (k == 120 || k == 330) begin
				squeeze    = 1'b1;
				burst_left = 40;
			end
			if (k == 240)
				drain_all();

			case ($urandom_range(0, 9))
				0:       it.entry_key = '0;
				1:       it.entry_key = '1;
				2, 3, 4: it.entry_key = KEY_BITS'($urandom_range(200, 203)); // ties
				default: it.entry_key = KEY_BITS'($urandom);
			endcase
			if ($urandom_range(0, 4) == 0)
				it.entry_id = ID_BITS'($urandom_range(0, 7));   // repeated ids
			else
				it.entry_id = ID_BITS'($urandom);

			insert_share = (mix == FILL_UP) ? 75 : (mix == DRAIN_DOWN) ? 25 : 50;
			i = $urandom_range(0, 99);
			if (i < 3) begin
				it.kind = OP_NONE;
			end else if (i < insert_share) begin
				it.kind = OP_INSERT;
			end else if ($urandom_range(0, 1) == 0) begin
				it.kind = OP_POP;
			end else begin
				it.kind = OP_REMOVE;
				// mostly aim at an id that is held right now
				if (held_count != 0 && $urandom_range(0, 3) != 0)
					it.entry_id = held_id[$urandom_range(0, held_count - 1)];
			end

			if (it.kind != OP_NONE)
				n_real++;
			k++;
			offer_item(it, 1'b0, blank);
		end

		// wait out everything owed, then a few more cycles for strays
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("requests: %0d inserts, %0d pops, %0d removals by id, %0d unused; deepest fill %0d",
			n_insert, n_pop, n_remove, n_none, deepest);
		$display("outcomes: %0d full, %0d empty, %0d id absent; %0d results, %0d mismatches",
			n_full, n_empty, n_missing, results_seen, mismatches);
		if (mismatches == 0)
			$display("sorted_priority_queue_unit_test: PASS");
		else
			$display("sorted_priority_queue_unit_test: FAIL");
		$finish;
	end

endmodule
